FILE: src/lpfd_pkg.sv
// Shared types and constants for the length-prefixed frame deframer.
package lpfd_pkg;

	localparam int unsigned HEADER_BYTES = 12;
	localparam logic [3:0] HDR_LAST_IDX = 4'(HEADER_BYTES - 1);
	localparam logic [3:0] LEN_END_IDX = 4'd4;
	localparam logic [3:0] CID_END_IDX = 4'd8;

	typedef enum logic [1:0] {
		CMD_BYTE  = 2'd0,
		CMD_TICK  = 2'd1,
		CMD_ABORT = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_HEADER    = 3'd0,
		ST_PAYLOAD   = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_LEN_ERR   = 3'd3,
		ST_THROTTLED = 3'd4,
		ST_WINDOW    = 3'd5,
		ST_ABORTED   = 3'd6,
		ST_UNUSED    = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		REG_MAX_LEN = 2'd0,
		REG_BUDGET  = 2'd1,
		REG_CLASS   = 2'd2,
		REG_NONE    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] backend_ident;
		logic [31:0] client_ident;
		logic [23:0] frame_len;
		logic [7:0]  payload_byte;
		logic        high_priority;
		logic        last;
		status_t     status;
	} result_t;

endpackage

FILE: src/length_prefixed_frame_deframer.sv
// Top level of the length-prefixed frame deframer: header parser, throttle and output stage.
//
// Input stream (s_*): one word per transfer. s_tuser carries the command
// (stream byte, window tick, abort), s_tdata the stream byte.
// Output stream (m_*): one result word for every accepted input word except
// the unused command. m_tuser carries status and the high priority flag,
// m_tlast the final payload byte or empty-frame mark, m_tdata the payload
// byte and the header fields of the frame.
// Config port (cfg_*): register writes, taken in any cycle; write only while
// the stream is idle.
// Throughput: one word per cycle while s_tready is high; the next parser
// state is computed combinationally from the current state and the incoming
// byte.
// A two-entry output stage (output register and skid register) decouples the
// sides: when the receiver stalls, one more word is taken into the skid
// register and s_tready then drops until the receiver takes a word.
// Reset clears the parser, the window counter and the output stage, and loads
// the register reset values (max length 1048576, budget 0, control class 1).
module length_prefixed_frame_deframer
	import lpfd_pkg::*;
#(
	parameter int unsigned LEN_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [1:0]  s_tuser,   // [1:0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // [7:0] payload_byte, [31:8] frame_len,
	                               // [63:32] client_ident, [95:64] backend_ident
	output logic [3:0]  m_tuser,   // [2:0] status, [3] high_priority
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [23:0] max_len_q;
	logic [31:0] budget_q;
	logic [7:0]  class_q;

	logic [3:0]          header_index_q;
	logic [31:0]         length_word_q;
	logic [31:0]         client_word_q;
	logic [31:0]         backend_word_q;
	logic [LEN_BITS-1:0] payload_left_q;
	logic                in_payload_q;
	logic                priority_flag_q;
	logic [31:0]         window_count_q;

	logic    out_v_q, skid_v_q;
	result_t out_q, skid_q;

	cmd_t    cmd;
	logic    accept, push, pop;
	result_t res;

	logic [3:0]          hidx_n;
	logic [31:0]         len_n, cid_n, bid_n;
	logic [LEN_BITS-1:0] left_n;
	logic                inp_n, prio_n, clear_n;
	logic [31:0]         wc_n;
	logic                throttled, len_over, len_bad, first_byte, is_last, prio_cur;
	logic [23:0]         len_shown;

	assign cmd       = cmd_t'(s_tuser);
	assign s_tready  = !skid_v_q;
	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;
	assign push      = accept && (cmd != CMD_NONE);
	assign pop       = out_v_q && m_tready;

	assign throttled  = (budget_q != 32'd0) && (window_count_q >= budget_q);
	assign len_over   = (len_n >> LEN_BITS) != 32'd0;
	assign len_bad    = (len_n > {8'd0, max_len_q}) || len_over;
	assign len_shown  = (len_n[31:24] != 8'd0) ? 24'hFF_FFFF : len_n[23:0];
	assign first_byte = {{(32 - LEN_BITS){1'b0}}, payload_left_q} == length_word_q;
	assign is_last    = payload_left_q <= LEN_BITS'(1);
	assign prio_cur   = first_byte ? (s_tdata == class_q) : priority_flag_q;

	always_comb begin
		hidx_n  = header_index_q;
		len_n   = length_word_q;
		cid_n   = client_word_q;
		bid_n   = backend_word_q;
		left_n  = payload_left_q;
		inp_n   = in_payload_q;
		prio_n  = priority_flag_q;
		clear_n = 1'b0;
		wc_n    = window_count_q;
		res     = '0;
		res.status = ST_HEADER;
		unique case (cmd)
			CMD_BYTE: begin
				if (throttled) begin
					res.status = ST_THROTTLED;
				end else begin
					if (window_count_q != 32'hFFFF_FFFF)
						wc_n = window_count_q + 32'd1;
					if (!in_payload_q) begin
						if (header_index_q < LEN_END_IDX)
							len_n = {length_word_q[23:0], s_tdata};
						else if (header_index_q < CID_END_IDX)
							cid_n = {client_word_q[23:0], s_tdata};
						else
							bid_n = {backend_word_q[23:0], s_tdata};
						if (header_index_q != HDR_LAST_IDX) begin
							hidx_n = header_index_q + 4'd1;
						end else if (len_bad) begin
							res.status        = ST_LEN_ERR;
							res.frame_len     = len_shown;
							res.client_ident  = cid_n;
							res.backend_ident = bid_n;
							clear_n           = 1'b1;
						end else if (len_n == 32'd0) begin
							res.status        = ST_EMPTY;
							res.client_ident  = cid_n;
							res.backend_ident = bid_n;
							res.last          = 1'b1;
							clear_n           = 1'b1;
						end else begin
							hidx_n            = 4'd0;
							inp_n             = 1'b1;
							left_n            = len_n[LEN_BITS-1:0];
							res.frame_len     = len_n[23:0];
							res.client_ident  = cid_n;
							res.backend_ident = bid_n;
						end
					end else begin
						prio_n            = prio_cur;
						res.status        = ST_PAYLOAD;
						res.payload_byte  = s_tdata;
						res.frame_len     = length_word_q[23:0];
						res.client_ident  = client_word_q;
						res.backend_ident = backend_word_q;
						res.high_priority = prio_cur;
						res.last          = is_last;
						if (is_last)
							clear_n = 1'b1;
						else
							left_n = payload_left_q - LEN_BITS'(1);
					end
				end
			end
			CMD_TICK: begin
				wc_n       = 32'd0;
				res.status = ST_WINDOW;
			end
			CMD_ABORT: begin
				clear_n    = 1'b1;
				res.status = ST_ABORTED;
			end
			CMD_NONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= 24'd1048576;
			budget_q  <= 32'd0;
			class_q   <= 8'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MAX_LEN: max_len_q <= cfg_data[23:0];
				REG_BUDGET:  budget_q  <= cfg_data;
				REG_CLASS:   class_q   <= cfg_data[7:0];
				REG_NONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_index_q  <= 4'd0;
			length_word_q   <= 32'd0;
			client_word_q   <= 32'd0;
			backend_word_q  <= 32'd0;
			payload_left_q  <= '0;
			in_payload_q    <= 1'b0;
			priority_flag_q <= 1'b0;
			window_count_q  <= 32'd0;
		end else if (accept) begin
			window_count_q <= wc_n;
			if (clear_n) begin
				header_index_q  <= 4'd0;
				length_word_q   <= 32'd0;
				client_word_q   <= 32'd0;
				backend_word_q  <= 32'd0;
				payload_left_q  <= '0;
				in_payload_q    <= 1'b0;
				priority_flag_q <= 1'b0;
			end else begin
				header_index_q  <= hidx_n;
				length_word_q   <= len_n;
				client_word_q   <= cid_n;
				backend_word_q  <= bid_n;
				payload_left_q  <= left_n;
				in_payload_q    <= inp_n;
				priority_flag_q <= prio_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop)
				skid_v_q <= 1'b0;
		end else if (push) begin
			if (!out_v_q || pop)
				out_v_q <= 1'b1;
			else
				skid_v_q <= 1'b1;
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop)
				out_q <= skid_q;
		end else if (push) begin
			if (!out_v_q || pop)
				out_q <= res;
			else
				skid_q <= res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {out_q.backend_ident, out_q.client_ident, out_q.frame_len,
	                   out_q.payload_byte};
	assign m_tuser  = {out_q.high_priority, out_q.status};
	assign m_tlast  = out_q.last;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register holds a word while the output register is empty");

	a_stall_fills_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !m_tready && !skid_v_q && push) |=> skid_v_q)
		else $error("word taken during a stall was not held in the skid register");

	a_payload_no_header: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> (header_index_q == 4'd0))
		else $error("header index advanced while streaming payload");

	a_header_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		header_index_q <= HDR_LAST_IDX)
		else $error("header index beyond the header length");

	a_throttle_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == CMD_BYTE && throttled) |=>
		($stable(window_count_q) && $stable(header_index_q) && $stable(in_payload_q)))
		else $error("throttled byte changed parser state");

endmodule

FILE: tb/testbench.sv
// Testbench for the length-prefixed frame deframer: directed table, then random frames checked against a predictor.
`timescale 1ns / 1ps

module testbench
	import lpfd_pkg::*;
();

	localparam int unsigned LEN_BITS = 24;
	localparam logic [31:0] LEN_LIMIT = 32'hFFFF_FFFF >> (32 - LEN_BITS);
	localparam int STALL_LIMIT = 2000;

	localparam result_t HDR_ZERO   = '{32'h0, 32'h0, 24'h0, 8'h0, 1'b0, 1'b0, ST_HEADER};
	localparam result_t TICK_DONE  = '{32'h0, 32'h0, 24'h0, 8'h0, 1'b0, 1'b0, ST_WINDOW};
	localparam result_t ABORT_DONE = '{32'h0, 32'h0, 24'h0, 8'h0, 1'b0, 1'b0, ST_ABORTED};
	localparam result_t EMPTY_DONE = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'h0, 8'h0, 1'b0, 1'b1,
		ST_EMPTY};
	localparam result_t LEN_REJECT = '{32'h0, 32'h0, 24'hFF_FFFF, 8'h0, 1'b0, 1'b0, ST_LEN_ERR};

	typedef struct {
		cmd_t        cmd;
		logic [7:0]  data;
		bit          fixed;
		result_t     want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h0;   // [7:0] data_byte
	logic [1:0]  s_tuser = 2'h0;   // [1:0] cmd
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;          // [7:0] payload_byte, [31:8] frame_len,
	                               // [63:32] client_ident, [95:64] backend_ident
	logic [3:0]  m_tuser;          // [2:0] status, [3] high_priority
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 2'h0;
	logic [31:0] cfg_data = 32'h0;

	logic [3:0]  hdr_count;
	logic [31:0] len_word;
	logic [31:0] cid_word;
	logic [31:0] bid_word;
	logic [23:0] pay_left;
	logic        in_body;
	logic        prio_flag;
	logic [31:0] win_bytes;
	logic [23:0] lim_max_len;
	logic [31:0] lim_budget;
	logic [7:0]  ctl_class;

	result_t due_results[$];
	int      errors = 0;
	int      taken_items = 0;
	int      quiet_cycles = 0;
	bit      calm = 1'b0;

	length_prefixed_frame_deframer #(.LEN_BITS(LEN_BITS)) dut (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	always #4 clk = ~clk;

	function automatic void parser_clear();
		hdr_count = '0;
		len_word = '0;
		cid_word = '0;
		bid_word = '0;
		pay_left = '0;
		in_body = 1'b0;
		prio_flag = 1'b0;
	endfunction

	function automatic bit deframe_predict(input cmd_t cmd, input logic [7:0] b,
			output result_t r);
		logic is_last;
		r = '0;
		case (cmd)
			CMD_BYTE: begin
				if (lim_budget != 0 && win_bytes >= lim_budget) begin
					r.status = ST_THROTTLED;
					return 1'b1;
				end
				if (win_bytes != 32'hFFFF_FFFF)
					win_bytes++;
				if (!in_body) begin
					if (hdr_count < LEN_END_IDX)
						len_word = {len_word[23:0], b};
					else if (hdr_count < CID_END_IDX)
						cid_word = {cid_word[23:0], b};
					else
						bid_word = {bid_word[23:0], b};
					if (hdr_count != HDR_LAST_IDX) begin
						hdr_count++;
						r.status = ST_HEADER;
						return 1'b1;
					end
					hdr_count = '0;
					r.client_ident = cid_word;
					r.backend_ident = bid_word;
					if (len_word > {8'h0, lim_max_len} || len_word > LEN_LIMIT) begin
						r.status = ST_LEN_ERR;
						r.frame_len = (len_word > 32'hFF_FFFF) ? 24'hFF_FFFF : len_word[23:0];
						parser_clear();
					end else if (len_word == 0) begin
						r.status = ST_EMPTY;
						r.last = 1'b1;
						parser_clear();
					end else begin
						in_body = 1'b1;
						pay_left = len_word[23:0];
						r.status = ST_HEADER;
						r.frame_len = len_word[23:0];
					end
					return 1'b1;
				end
				if ({8'h0, pay_left} == len_word)
					prio_flag = (b == ctl_class);
				is_last = (pay_left <= 1);
				r.status = ST_PAYLOAD;
				r.payload_byte = b;
				r.frame_len = len_word[23:0];
				r.client_ident = cid_word;
				r.backend_ident = bid_word;
				r.high_priority = prio_flag;
				r.last = is_last;
				if (is_last)
					parser_clear();
				else
					pay_left--;
				return 1'b1;
			end
			CMD_TICK: begin
				win_bytes = '0;
				r.status = ST_WINDOW;
				return 1'b1;
			end
			CMD_ABORT: begin
				parser_clear();
				r.status = ST_ABORTED;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic send_word(input cmd_t cmd, input logic [7:0] b, input bit fixed = 1'b0,
			input result_t want = '0);
		result_t r;
		bit has_result;
		if (!calm) begin
			while ($urandom_range(99) < 6) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		has_result = deframe_predict(cmd, b, r);
		if (has_result)
			due_results.push_back(fixed ? want : r);
		if (cmd != CMD_NONE)
			taken_items++;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_regs(input logic [23:0] mx, input logic [31:0] bud,
			input logic [7:0] cls, input bit poke_unused);
		logic [31:0] vals [4];
		int n;
		vals[0] = {8'($urandom), mx};
		vals[1] = bud;
		vals[2] = {24'($urandom), cls};
		vals[3] = $urandom;
		n = poke_unused ? 4 : 3;
		for (int i = 0; i < n; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= reg_idx_t'(i);
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			case (reg_idx_t'(i))
				REG_MAX_LEN: lim_max_len = vals[i][23:0];
				REG_BUDGET:  lim_budget = vals[i];
				REG_CLASS:   ctl_class = vals[i][7:0];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		result_t want;
		if (m_tvalid === 1'b1 && m_tready) begin
			if (due_results.size() == 0) begin
				$display("%0t unexpected word: status %0d tdata %h", $time, m_tuser[2:0], m_tdata);
				errors++;
			end else begin
				want = due_results.pop_front();
				if (m_tuser[2:0] !== want.status) begin
					$display("%0t status: expected %0d got %0d", $time, want.status, m_tuser[2:0]);
					errors++;
				end
				if (m_tdata[7:0] !== want.payload_byte) begin
					$display("%0t payload_byte: expected %h got %h", $time, want.payload_byte,
						m_tdata[7:0]);
					errors++;
				end
				if (m_tdata[31:8] !== want.frame_len) begin
					$display("%0t frame_len: expected %h got %h", $time, want.frame_len,
						m_tdata[31:8]);
					errors++;
				end
				if (m_tdata[63:32] !== want.client_ident) begin
					$display("%0t client_ident: expected %h got %h", $time, want.client_ident,
						m_tdata[63:32]);
					errors++;
				end
				if (m_tdata[95:64] !== want.backend_ident) begin
					$display("%0t backend_ident: expected %h got %h", $time, want.backend_ident,
						m_tdata[95:64]);
					errors++;
				end
				if (m_tuser[3] !== want.high_priority) begin
					$display("%0t high_priority: expected %b got %b", $time, want.high_priority,
						m_tuser[3]);
					errors++;
				end
				if (m_tlast !== want.last) begin
					$display("%0t last: expected %b got %b", $time, want.last, m_tlast);
					errors++;
				end
			end
		end
		m_tready <= calm || ($urandom_range(99) >= 6);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		stim_row_t   script[$];
		logic [31:0] flen;
		logic [95:0] hdr;
		logic [23:0] mx;
		logic [31:0] bud;
		logic [7:0]  pb;
		int          pick;
		int          npay;
		int          goal;

		parser_clear();
		win_bytes = '0;
		lim_max_len = 24'd1048576;
		lim_budget = '0;
		ctl_class = 8'd1;

		script = '{
			'{CMD_TICK,  8'h00, 1'b1, TICK_DONE},
			'{CMD_NONE,  8'hFF, 1'b0, HDR_ZERO},
			'{CMD_ABORT, 8'h00, 1'b1, ABORT_DONE},
			'{CMD_BYTE,  8'h00, 1'b1, HDR_ZERO},
			'{CMD_BYTE,  8'h00, 1'b1, HDR_ZERO},
			'{CMD_BYTE,  8'h00, 1'b1, HDR_ZERO},
			'{CMD_BYTE,  8'h00, 1'b1, HDR_ZERO},
			'{CMD_BYTE,  8'hFF, 1'b1, HDR_ZERO},
			'{CMD_BYTE,  8'hFF, 1'b1, HDR_ZERO},
			'{CMD_BYTE,  8'hFF, 1'b1, HDR_ZERO},
			'{CMD_BYTE,  8'hFF, 1'b1, HDR_ZERO},
			'{CMD_BYTE,  8'hFF, 1'b1, HDR_ZERO},
			'{CMD_BYTE,  8'hFF, 1'b1, HDR_ZERO},
			'{CMD_BYTE,  8'hFF, 1'b1, HDR_ZERO},
			'{CMD_BYTE,  8'hFF, 1'b1, EMPTY_DONE},
			'{CMD_BYTE,  8'hFF, 1'b1, HDR_ZERO},
			'{CMD_BYTE,  8'hFF, 1'b1, HDR_ZERO},
			'{CMD_BYTE,  8'hFF, 1'b1, HDR_ZERO},
			'{CMD_BYTE,  8'hFF, 1'b1, HDR_ZERO},
			'{CMD_BYTE,  8'h00, 1'b1, HDR_ZERO},
			'{CMD_BYTE,  8'h00, 1'b1, HDR_ZERO},
			'{CMD_BYTE,  8'h00, 1'b1, HDR_ZERO},
			'{CMD_BYTE,  8'h00, 1'b1, HDR_ZERO},
			'{CMD_BYTE,  8'h00, 1'b1, HDR_ZERO},
			'{CMD_BYTE,  8'h00, 1'b1, HDR_ZERO},
			'{CMD_BYTE,  8'h00, 1'b1, HDR_ZERO},
			'{CMD_BYTE,  8'h00, 1'b1, LEN_REJECT}
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			send_word(script[i].cmd, script[i].data, script[i].fixed, script[i].want);

		for (int phase = 0; phase < 8; phase++) begin
			settle();
			case (phase)
				0: ;
				1: apply_regs(24'hFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1);
				2: apply_regs(24'h0, 32'h1, 8'h00, 1'b1);
				3: apply_regs(24'd16, 32'h0, 8'($urandom), 1'b0);
				default: begin
					case ($urandom_range(2))
						0: mx = 24'($urandom_range(20));
						1: mx = 24'($urandom);
						default: mx = 24'd1048576;
					endcase
					case ($urandom_range(2))
						0: bud = 32'h0;
						1: bud = 32'($urandom_range(4, 40));
						default: bud = $urandom;
					endcase
					apply_regs(mx, bud, 8'($urandom), 1'($urandom_range(1)));
				end
			endcase
			calm = (phase == 3);
			goal = taken_items + 230;
			while (taken_items < goal) begin
				pick = $urandom_range(99);
				if (pick < 70) begin
					pick = $urandom_range(99);
					if (pick < 70)
						flen = $urandom_range(16);
					else if (pick < 80)
						flen = {8'h0, lim_max_len} + 32'($urandom_range(1, 3));
					else if (pick < 90)
						flen = $urandom;
					else
						flen = (lim_max_len <= 64) ? {8'h0, lim_max_len} : 32'($urandom_range(64));
					hdr = {flen, 32'($urandom), 32'($urandom)};
					npay = (flen <= 64) ? int'(flen) : 0;
					for (int k = 0; k < HEADER_BYTES + npay; k++) begin
						if (lim_budget != 0 && $urandom_range(11) == 0)
							send_word(CMD_TICK, 8'($urandom));
						if ($urandom_range(79) == 0)
							send_word(CMD_ABORT, 8'($urandom));
						if (k < HEADER_BYTES)
							pb = hdr[95 - 8*k -: 8];
						else if (k == HEADER_BYTES && $urandom_range(1))
							pb = ctl_class;
						else
							pb = 8'($urandom);
						send_word(CMD_BYTE, pb);
					end
				end else if (pick < 80) begin
					send_word(CMD_TICK, 8'($urandom));
				end else if (pick < 86) begin
					send_word(CMD_ABORT, 8'($urandom));
				end else if (pick < 90) begin
					send_word(CMD_NONE, 8'($urandom));
				end else begin
					repeat ($urandom_range(1, 8))
						send_word(CMD_BYTE, 8'($urandom));
				end
			end
			calm = 1'b0;
		end

		settle();
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
src/lpfd_pkg.sv
src/length_prefixed_frame_deframer.sv
tb/testbench.sv
